/* hdl/brst_pkg.sv */
// ----------------------------------------------------------------------------
// brst_pkg
// Shared types and constants for the block range-sum table: item formats,
// command codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package brst_pkg;

  localparam int IDX_W  = 9;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;

  // Element count after reset.
  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

  // Item command codes.
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     range_error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic div_start;
    logic load_pos;
    logic upd_rd;
    logic upd_wr;
    logic walk_step;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic item_err;
    logic item_upd;
    logic div_busy;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/brst_div.sv */
// ----------------------------------------------------------------------------
// brst_div
// Index splitter: divides a 0-based element index by the block length with a
// reciprocal multiplication, giving the block number and the offset inside
// the block. The dividend is registered at start, the quotient while busy.
// ----------------------------------------------------------------------------
module brst_div #(
  parameter int BLK_LEN = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [brst_pkg::IDX_W-1:0] dividend,
  output logic                       busy,
  output logic [brst_pkg::IDX_W-1:0] quotient,
  output logic [$clog2(BLK_LEN)-1:0] remainder
);

  localparam int OW = $clog2(BLK_LEN);
  localparam int SH = brst_pkg::IDX_W + OW;
  localparam int MW = brst_pkg::IDX_W + 2;
  localparam int PW = brst_pkg::IDX_W + MW;
  // The multiplier is 2^SH / BLK_LEN rounded up. With SH chosen this way the
  // rounding error never reaches the next integer for any 9-bit dividend.
  localparam logic [PW-1:0] RECIP = PW'(((1 << SH) + BLK_LEN - 1) / BLK_LEN);

  logic [brst_pkg::IDX_W-1:0] dvd_r;
  logic [brst_pkg::IDX_W-1:0] quo_r;
  logic                       busy_r;
  logic [PW-1:0]              prod;
  logic [brst_pkg::IDX_W-1:0] back;
  logic [brst_pkg::IDX_W-1:0] rem_full;

  assign prod     = PW'(dvd_r) * RECIP;
  assign back     = quo_r * brst_pkg::IDX_W'(BLK_LEN);
  assign rem_full = dvd_r - back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (busy_r) begin
      quo_r <= brst_pkg::IDX_W'(prod >> SH);
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_full[OW-1:0];

endmodule

/* hdl/brst_dp.sv */
// ----------------------------------------------------------------------------
// brst_dp
// Datapath: element and block-sum memories, item and count registers, the
// index divider, the range walker with its accumulator, and the result
// register.
// ----------------------------------------------------------------------------
module brst_dp #(
  parameter int ELEMENTS = 256,
  parameter int BLK_LEN  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brst_pkg::ctrl_cmd_t        cmd,
  output brst_pkg::dp_stat_t         stat,
  input  brst_pkg::in_item_t         in_data,
  input  logic                       cfg_we,
  input  logic [brst_pkg::CNT_W-1:0] cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output brst_pkg::out_item_t        out_data
);

  localparam int NB = (ELEMENTS + BLK_LEN - 1) / BLK_LEN;
  localparam int AW = $clog2(ELEMENTS);
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int OW = $clog2(BLK_LEN);
  localparam int PW = brst_pkg::IDX_W + 1;
  localparam logic [31:0] ELEM_LIM = 32'(ELEMENTS);
  localparam logic [31:0] NB_LIM   = 32'(NB);

  logic [brst_pkg::DATA_W-1:0] elem_mem [ELEMENTS];
  logic [brst_pkg::DATA_W-1:0] bs_mem   [NB];

  logic [brst_pkg::CNT_W-1:0]  count_r;
  brst_pkg::in_item_t          item_r;
  logic [AW-1:0]               clr_cnt_r;
  logic [PW-1:0]               i_r;
  logic [BW-1:0]               blk_r;
  logic [OW-1:0]               off_r;
  logic [brst_pkg::DATA_W-1:0] acc_r;
  logic                        pend_elem_r;
  logic                        pend_blk_r;
  logic [brst_pkg::DATA_W-1:0] elem_q_r;
  logic [brst_pkg::DATA_W-1:0] bs_q_r;
  logic                        out_valid_r;
  brst_pkg::out_item_t         out_r;

  logic [brst_pkg::IDX_W-1:0]  lo;
  logic [brst_pkg::IDX_W-1:0]  hi;
  logic                        first_bad;
  logic                        last_bad;
  logic                        item_err;
  logic                        take_blk;
  logic [PW-1:0]               i_step;
  logic                        div_busy;
  logic [brst_pkg::IDX_W-1:0]  quo;
  logic [OW-1:0]               rem;

  logic                        elem_we;
  logic [AW-1:0]               elem_wa;
  logic [brst_pkg::DATA_W-1:0] elem_wd;
  logic                        elem_re;
  logic                        bs_we;
  logic [BW-1:0]               bs_wa;
  logic [brst_pkg::DATA_W-1:0] bs_wd;
  logic                        bs_re;

  // Index checks against the count in use, which is also capped at ELEMENTS.
  assign lo = item_r.first_index - brst_pkg::IDX_W'(1);
  assign hi = item_r.last_index - brst_pkg::IDX_W'(1);

  assign first_bad = (item_r.first_index == '0) || (item_r.first_index > count_r) ||
                     (32'(item_r.first_index) > ELEM_LIM);
  assign last_bad  = (item_r.last_index == '0) || (item_r.last_index > count_r) ||
                     (32'(item_r.last_index) > ELEM_LIM);
  assign item_err  = (item_r.cmd == brst_pkg::CMD_UPDATE) ? first_bad :
                     (first_bad || last_bad || (item_r.first_index > item_r.last_index));

  brst_div #(
    .BLK_LEN(BLK_LEN)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lo),
    .busy     (div_busy),
    .quotient (quo),
    .remainder(rem)
  );

  // A whole block is taken from its sum when the walk sits at its start and
  // the block ends at or before the last index.
  assign take_blk = (off_r == '0) &&
                    ((i_r + PW'(BLK_LEN - 1)) <= {1'b0, hi});
  assign i_step   = take_blk ? (i_r + PW'(BLK_LEN)) : (i_r + PW'(1));

  assign elem_re = cmd.upd_rd || (cmd.walk_step && !take_blk);
  assign bs_re   = cmd.upd_rd || (cmd.walk_step && take_blk);

  assign elem_we = cmd.clr_step || cmd.upd_wr;
  assign elem_wa = cmd.clr_step ? clr_cnt_r : AW'(i_r);
  assign elem_wd = cmd.clr_step ? '0 : item_r.new_value;

  assign bs_we = (cmd.clr_step && (32'(clr_cnt_r) < NB_LIM)) || cmd.upd_wr;
  assign bs_wa = cmd.clr_step ? BW'(clr_cnt_r) : blk_r;
  assign bs_wd = cmd.clr_step ? '0 : (bs_q_r + item_r.new_value - elem_q_r);

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_wa] <= elem_wd;
    end
    if (elem_re) begin
      elem_q_r <= elem_mem[AW'(i_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (bs_we) begin
      bs_mem[bs_wa] <= bs_wd;
    end
    if (bs_re) begin
      bs_q_r <= bs_mem[blk_r];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= brst_pkg::COUNT_RESET;
      clr_cnt_r   <= '0;
      pend_elem_r <= 1'b0;
      pend_blk_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      pend_elem_r <= cmd.walk_step && !take_blk;
      pend_blk_r  <= cmd.walk_step && take_blk;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.load_pos) begin
      i_r   <= {1'b0, lo};
      blk_r <= BW'(quo);
      off_r <= rem;
      acc_r <= '0;
    end else begin
      if (cmd.walk_step) begin
        i_r <= i_step;
        if (take_blk) begin
          blk_r <= blk_r + BW'(1);
        end else if (off_r == OW'(BLK_LEN - 1)) begin
          off_r <= '0;
          blk_r <= blk_r + BW'(1);
        end else begin
          off_r <= off_r + OW'(1);
        end
      end
      if (pend_elem_r) begin
        acc_r <= acc_r + elem_q_r;
      end else if (pend_blk_r) begin
        acc_r <= acc_r + bs_q_r;
      end
    end
    if (cmd.load_out) begin
      out_r.range_sum   <= item_err ? '0 : acc_r;
      out_r.range_error <= item_err;
    end
  end

  assign stat.clr_last  = (clr_cnt_r == AW'(ELEMENTS - 1));
  assign stat.item_err  = item_err;
  assign stat.item_upd  = (item_r.cmd == brst_pkg::CMD_UPDATE);
  assign stat.div_busy  = div_busy;
  assign stat.walk_last = (i_step > {1'b0, hi});
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/brst_ctrl.sv */
// ----------------------------------------------------------------------------
// brst_ctrl
// Controller: sequences the clearing sweep, the item check, the index split,
// the update read-modify-write and the query walk, and issues the result.
// ----------------------------------------------------------------------------
module brst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brst_pkg::dp_stat_t  stat,
  output brst_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_UPD_RD = 9'b000010000,
    S_UPD_WR = 9'b000100000,
    S_WALK   = 9'b001000000,
    S_DRAIN  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.item_err) begin
          state_nxt = stat.item_upd ? S_IDLE : S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.load_pos = 1'b1;
          state_nxt    = stat.item_upd ? S_UPD_RD : S_WALK;
        end
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/block_range_sum_table_core.sv */
// ----------------------------------------------------------------------------
// block_range_sum_table_core
// Square-root decomposition range-sum table: an element array plus one
// running sum per block, with point updates and inclusive range-sum queries.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_valid / in_ready     in_item_t (cmd, indices, value)
//   out_      output     out_valid / out_ready   out_item_t (range_sum, error)
//   cfg_      input      cfg_we (no wait)        cfg_data = element count
//
// After reset, clearing all elements and block sums holds in_ready low.
// Each item is checked and its first index split by the divider. An update
// then reads and rewrites one element and one block sum. A query walks one
// element or one whole block sum per cycle. A bad index ends an update with
// no write and sends a query straight to its error result. A new item is
// taken only once the previous one is done. A query's result waits only
// while the previous result is still unaccepted.
// ----------------------------------------------------------------------------
module block_range_sum_table_core #(
  parameter int ELEMENTS = 256,
  parameter int BLK_LEN  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  brst_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output brst_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [brst_pkg::CNT_W-1:0] cfg_data
);

  brst_pkg::ctrl_cmd_t ctl_cmd;
  brst_pkg::dp_stat_t  dp_stat;

  // The controller owns sequencing; the datapath owns all storage and math.
  brst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (dp_stat),
    .cmd     (ctl_cmd)
  );

  brst_dp #(
    .ELEMENTS(ELEMENTS),
    .BLK_LEN (BLK_LEN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ctl_cmd),
    .stat     (dp_stat),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the block from taking another item back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  // The divider never runs while new items are taken.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.div_busy |-> !in_ready)
    else $error("divider busy while ready for an item");

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.load_out |-> dp_stat.out_free)
    else $error("result overwrites a waiting result");

  // No two datapath commands are ever issued together.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl_cmd.clr_step, ctl_cmd.latch, ctl_cmd.div_start, ctl_cmd.load_pos,
              ctl_cmd.upd_rd, ctl_cmd.upd_wr, ctl_cmd.walk_step, ctl_cmd.load_out}))
    else $error("overlapping datapath commands");
`endif

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block range-sum table. It keeps its own copy of
// the element array, the block sums and the element count, predicts the answer
// of every accepted query, and compares each returned item field by field
// against the oldest open prediction. Directed items cover index extremes,
// all error cases and the count register limits. Random traffic then runs
// under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int ELEMENTS      = 256;
  localparam int BLK_LEN       = 16;
  localparam int NUM_BLOCKS    = (ELEMENTS + BLK_LEN - 1) / BLK_LEN;
  // Covers any update still in flight after the last answer.
  localparam int SETTLE_CYCLES = 96;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SEGMENT_ITEMS = 145;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  brst_pkg::in_item_t         in_data;
  logic                       out_valid;
  logic                       out_ready;
  brst_pkg::out_item_t        out_data;
  logic                       cfg_we;
  logic [brst_pkg::CNT_W-1:0] cfg_data;

  // Shadow copy of the table contents and the element count register.
  logic [brst_pkg::DATA_W-1:0] table_elems [ELEMENTS];
  logic [brst_pkg::DATA_W-1:0] table_block_sums [NUM_BLOCKS];
  logic [brst_pkg::CNT_W-1:0]  table_count;

  // Answers predicted for accepted queries, oldest first.
  brst_pkg::out_item_t pending_answers [$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  block_range_sum_table_core #(
    .ELEMENTS(ELEMENTS),
    .BLK_LEN (BLK_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // A count register above the array size behaves as the array size.
  function automatic int unsigned count_in_use();
    return (table_count > ELEMENTS) ? ELEMENTS : table_count;
  endfunction

  // Works out the answer to one query from the shadow table. The edge blocks
  // are summed element by element and the blocks in between from the block
  // sums, so stale values past a lowered count are never picked up.
  function automatic brst_pkg::out_item_t predict_answer(brst_pkg::in_item_t it);
    brst_pkg::out_item_t ans;
    int unsigned         cnt;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         bs;
    int unsigned         be;
    int unsigned         i;
    cnt = count_in_use();
    ans.range_sum   = '0;
    ans.range_error = 1'b1;
    if (it.first_index != 0 && it.last_index != 0 && it.first_index <= cnt &&
        it.last_index <= cnt && it.first_index <= it.last_index) begin
      ans.range_error = 1'b0;
      lo = it.first_index - 1;
      hi = it.last_index - 1;
      bs = lo / BLK_LEN;
      be = hi / BLK_LEN;
      if (bs == be) begin
        for (i = lo; i <= hi; i++) ans.range_sum += table_elems[i];
      end else begin
        for (i = lo; i < (bs + 1) * BLK_LEN; i++) ans.range_sum += table_elems[i];
        for (i = bs + 1; i < be; i++) ans.range_sum += table_block_sums[i];
        for (i = be * BLK_LEN; i <= hi; i++) ans.range_sum += table_elems[i];
      end
    end
    return ans;
  endfunction

  function automatic brst_pkg::in_item_t pack_item(logic cmd, int unsigned first,
                                                   int unsigned last,
                                                   logic [brst_pkg::DATA_W-1:0] value);
    brst_pkg::in_item_t it;
    it.cmd         = cmd;
    it.first_index = brst_pkg::IDX_W'(first);
    it.last_index  = brst_pkg::IDX_W'(last);
    it.new_value   = value;
    return it;
  endfunction

  // Mostly well-formed items with random content, some deliberately broken
  // ones (zero index, index past the count, reversed range) and some noise.
  function automatic brst_pkg::in_item_t random_item();
    brst_pkg::in_item_t it;
    int unsigned        cnt;
    int unsigned        roll;
    int unsigned        top;
    cnt  = count_in_use();
    roll = $urandom_range(99);
    it.cmd         = ($urandom_range(99) < 45) ? brst_pkg::CMD_UPDATE : brst_pkg::CMD_QUERY;
    it.first_index = brst_pkg::IDX_W'($urandom);
    it.last_index  = brst_pkg::IDX_W'($urandom);
    it.new_value   = $urandom;
    if (cnt != 0 && roll < 85) begin
      it.first_index = brst_pkg::IDX_W'($urandom_range(cnt, 1));
      if (roll < 35) begin
        // Short ranges, often inside one block or across a single boundary.
        top = it.first_index + BLK_LEN;
        if (top > cnt) top = cnt;
        it.last_index = brst_pkg::IDX_W'($urandom_range(top, it.first_index));
      end else begin
        it.last_index = brst_pkg::IDX_W'($urandom_range(cnt, it.first_index));
      end
    end else if (cnt != 0 && roll < 93) begin
      case ($urandom_range(2))
        0: begin
          if ($urandom_range(1) == 0) it.first_index = '0;
          else it.last_index = '0;
        end
        1: begin
          if ($urandom_range(1) == 0) it.first_index = brst_pkg::IDX_W'(cnt + 1);
          else it.last_index = brst_pkg::IDX_W'(cnt + 1);
        end
        default: begin
          if (cnt >= 2) begin
            it.first_index = brst_pkg::IDX_W'($urandom_range(cnt, 2));
            it.last_index  = brst_pkg::IDX_W'($urandom_range(it.first_index - 1, 1));
          end else begin
            it.first_index = '0;
          end
        end
      endcase
    end
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: it.new_value = 32'h7FFF_FFFF;
        1: it.new_value = 32'h8000_0000;
        2: it.new_value = 32'hFFFF_FFFF;
        default: it.new_value = '0;
      endcase
    end
    return it;
  endfunction

  // Sends an item; when taken, updates the shadow or queues its answer. Valid
  // is left high on return, so a following call can present the next item
  // back to back; anything that lets time pass must go through drain_results.
  task automatic send_item(brst_pkg::in_item_t it);
    int unsigned idx;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.cmd == brst_pkg::CMD_UPDATE) begin
      if (it.first_index != 0 && it.first_index <= count_in_use()) begin
        idx = it.first_index - 1;
        table_block_sums[idx / BLK_LEN] += it.new_value - table_elems[idx];
        table_elems[idx] = it.new_value;
      end
    end else begin
      pending_answers.push_back(predict_answer(it));
    end
  endtask

  // Holds the input channel idle until every predicted answer has come back,
  // then lets the given number of extra cycles pass for a trailing update.
  task automatic drain_results(int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_count(logic [brst_pkg::CNT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    table_count  = value;
  endtask

  // Everything reads as zero straight after reset.
  task automatic test_reset_state();
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, ELEMENTS, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, ELEMENTS, ELEMENTS, '0));
  endtask

  // Index extremes, block boundaries and every error case at the full count.
  task automatic test_index_edges();
    send_item(pack_item(brst_pkg::CMD_UPDATE, 1, 0, 32'h7FFF_FFFF));
    send_item(pack_item(brst_pkg::CMD_UPDATE, ELEMENTS, 511, 32'h8000_0000));
    send_item(pack_item(brst_pkg::CMD_UPDATE, BLK_LEN, 0, 32'hFFFF_FFFF));
    send_item(pack_item(brst_pkg::CMD_UPDATE, BLK_LEN + 1, 0, 32'd5));
    // Updates at a zero index or past the count must leave the table alone.
    send_item(pack_item(brst_pkg::CMD_UPDATE, 0, 3, 32'h1234_5678));
    send_item(pack_item(brst_pkg::CMD_UPDATE, ELEMENTS + 1, 0, 32'h1234_5678));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, ELEMENTS, 32'hFFFF_FFFF));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 1, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, BLK_LEN, BLK_LEN + 1, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 2, BLK_LEN - 1, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 3, 200, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 0, 5, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 5, 0, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 10, 9, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, ELEMENTS + 1, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 511, 511, 32'hFFFF_FFFF));
  endtask

  // Count register at zero, above the array size, shrunk and at one.
  task automatic test_count_register();
    drain_results(SETTLE_CYCLES);
    write_count(9'd0);
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 1, '0));
    send_item(pack_item(brst_pkg::CMD_UPDATE, 1, 0, 32'hDEAD_BEEF));
    drain_results(SETTLE_CYCLES);
    write_count(9'd511);
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, ELEMENTS, '0));
    drain_results(SETTLE_CYCLES);
    // Element 256 keeps its value while the count is lowered and must come
    // back into the full-range sum once the count is raised again.
    write_count(9'd20);
    send_item(pack_item(brst_pkg::CMD_UPDATE, 18, 0, 32'hCAFE_0001));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 20, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 21, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, BLK_LEN + 1, 20, '0));
    drain_results(SETTLE_CYCLES);
    write_count(9'd1);
    send_item(pack_item(brst_pkg::CMD_UPDATE, 1, 0, 32'd42));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 1, '0));
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, 2, '0));
    drain_results(SETTLE_CYCLES);
    write_count(brst_pkg::COUNT_RESET);
    send_item(pack_item(brst_pkg::CMD_QUERY, 1, ELEMENTS, '0));
  endtask

  // Three idling patterns, each with four count settings. Halfway through
  // every segment the input holds off until all answers are back.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned seg;
    int unsigned n;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin gap_pct = 20; stall_pct = 76; end
        1: begin gap_pct = 76; stall_pct = 20; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        drain_results(SETTLE_CYCLES);
        case (seg)
          0: write_count(brst_pkg::COUNT_RESET);
          1: write_count(brst_pkg::CNT_W'($urandom_range(ELEMENTS, 1)));
          2: write_count(brst_pkg::CNT_W'($urandom_range(ELEMENTS, 2 * BLK_LEN)));
          default: write_count(brst_pkg::CNT_W'($urandom_range(3 * BLK_LEN, 1)));
        endcase
        for (n = 0; n < SEGMENT_ITEMS; n++) begin
          if (n == SEGMENT_ITEMS / 2) drain_results(0);
          send_item(random_item());
        end
      end
    end
  endtask

  // Result side: random back-pressure and the field-by-field check.
  always @(posedge clk) begin : result_check
    brst_pkg::out_item_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result item: range_sum %0d, range_error %0b",
               out_data.range_sum, out_data.range_error);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data.range_sum !== want.range_sum) begin
          $error("range_sum: expected %0d, actual %0d", want.range_sum, out_data.range_sum);
          mismatch_count++;
        end
        if (out_data.range_error !== want.range_error) begin
          $error("range_error: expected %0b, actual %0b",
                 want.range_error, out_data.range_error);
          mismatch_count++;
        end
      end
    end
  end

  // Guards against a hung handshake or answers that never arrive.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_range_sum_table_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    gap_pct     = 20;
    stall_pct   = 76;
    table_count = brst_pkg::COUNT_RESET;
    foreach (table_elems[i]) table_elems[i] = '0;
    foreach (table_block_sums[i]) table_block_sums[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_index_edges();
    test_count_register();
    test_random_traffic();

    drain_results(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("block_range_sum_table_core: match");
    end else begin
      $display("block_range_sum_table_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/brst_pkg.sv
hdl/brst_div.sv
hdl/brst_dp.sv
hdl/brst_ctrl.sv
hdl/block_range_sum_table_core.sv
verif/tb.sv
